FILE: sv/scanned_mass_spring_oscillator_macros.svh
// ----------------------------------------------------------------------------
// Scanned mass-spring oscillator assertion macros
// Shared shorthands for the concurrent checks of the oscillator block.
// ----------------------------------------------------------------------------
`ifndef SCANNED_MASS_SPRING_OSCILLATOR_MACROS_SVH
`define SCANNED_MASS_SPRING_OSCILLATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sms_pkg.sv
// ----------------------------------------------------------------------------
// Scanned mass-spring oscillator package
// Shared types, codes and constant functions of the oscillator block.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int NUM_MASSES_DEF = 128;
  localparam int MAX_BURST_DEF  = 64;

  // Input operation codes.
  localparam logic [1:0] OP_GEN   = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_PLUCK = 2'd2;
  localparam logic [1:0] OP_EXC   = 2'd3;

  // Register indexes.
  localparam logic [2:0] REG_STEP  = 3'd0;
  localparam logic [2:0] REG_INV   = 3'd1;
  localparam logic [2:0] REG_DAMP  = 3'd2;
  localparam logic [2:0] REG_CENT  = 3'd3;
  localparam logic [2:0] REG_STIFF = 3'd4;
  localparam logic [2:0] REG_PINC  = 3'd5;

  // Work kinds carried down the head pipeline.
  localparam logic [2:0] K_VP    = 3'd0;
  localparam logic [2:0] K_ACC   = 3'd1;
  localparam logic [2:0] K_PLUCK = 3'd2;
  localparam logic [2:0] K_EXC   = 3'd3;
  localparam logic [2:0] K_GEN   = 3'd4;

  typedef struct packed {
    logic signed [23:0] p;
    logic signed [23:0] v;
    logic signed [23:0] a;
  } mass_t;

  typedef struct packed {
    logic  en;
    logic  wp;
    logic  wv;
    logic  wa;
    mass_t m;
  } wr_t;

  typedef struct packed {
    logic        valid;
    logic [11:0] sample;
  } gen_t;

  typedef struct packed {
    logic [15:0] step;
    logic [23:0] inv;
    logic [23:0] damp;
    logic [23:0] cent;
    logic [23:0] stiff;
    logic [23:0] pinc;
  } cfg_t;

  localparam wr_t NO_WR = '0;

  localparam longint SIN_PI   = 843314857;
  localparam longint SIN_HALF = 421657428;
  localparam longint SIN_ONE  = 268435456;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    logic signed [23:0] r;
    if (x > 64'sd8388607) begin
      r = 24'sh7fffff;
    end else if (x < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

  // Fixed-point sine by a folded Taylor series, Q4.28 angle in, Q1.14 out.
  function automatic logic signed [15:0] rom_sine(input longint x_in);
    longint x;
    longint x2;
    longint t;
    longint s;
    logic   neg;
    x = x_in;
    neg = 1'b0;
    if (x > SIN_PI) begin
      x = x - SIN_PI;
      neg = 1'b1;
    end
    if (x > SIN_HALF) begin
      x = SIN_PI - x;
    end
    if (x < 0) begin
      x = 0;
    end
    x2 = (x * x) >>> 28;
    t = SIN_ONE - x2 / 72;
    t = SIN_ONE - ((x2 * t) >>> 28) / 42;
    t = SIN_ONE - ((x2 * t) >>> 28) / 20;
    t = SIN_ONE - ((x2 * t) >>> 28) / 6;
    s = (x * t) >>> 28;
    s = (s + 8192) >>> 14;
    if (s > 16384) begin
      s = 16384;
    end
    return neg ? 16'(-s) : 16'(s);
  endfunction

endpackage

FILE: sv/sms_cell.sv
// ----------------------------------------------------------------------------
// Oscillator mass cell
// Holds one mass of the ring and takes its neighbor's mass every cycle.
// ----------------------------------------------------------------------------
module sms_cell (
  input  logic          clk,
  input  logic          rst,
  input  sms_pkg::mass_t nbr,
  input  sms_pkg::wr_t   wr,
  output sms_pkg::mass_t q
);

  sms_pkg::mass_t q_next;

  always_comb begin
    q_next = nbr;
    if (wr.en) begin
      if (wr.wp) begin
        q_next.p = wr.m.p;
      end
      if (wr.wv) begin
        q_next.v = wr.m.v;
      end
      if (wr.wa) begin
        q_next.a = wr.m.a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

FILE: sv/sms_rom.sv
// ----------------------------------------------------------------------------
// Oscillator pluck shape table
// Four Q1.14 shapes (sine, triangle, saw, square) built at elaboration.
// ----------------------------------------------------------------------------
module sms_rom #(
  parameter int NUM_MASSES = sms_pkg::NUM_MASSES_DEF
) (
  input  logic [$clog2(NUM_MASSES)-1:0] idx,
  input  logic [1:0]                    sel,
  output logic signed [15:0]            r0,
  output logic signed [15:0]            r1
);

  localparam int Q = NUM_MASSES / 4;

  logic signed [15:0] tab [4][NUM_MASSES];

  for (genvar i = 0; i < NUM_MASSES; i++) begin : g_ent
    localparam longint unsigned ANG = (64'd1674500375 * 64'(i)) / 64'(NUM_MASSES);
    localparam int TRI = (i < Q) ? (65536 * i) / NUM_MASSES :
                         (i > NUM_MASSES - Q) ?
                         (65536 * ((i + Q) % NUM_MASSES)) / NUM_MASSES - 16384 :
                         16384 - (65536 * (i - Q)) / NUM_MASSES;
    localparam int SAW = (32768 * ((i + NUM_MASSES / 2) % NUM_MASSES)) / NUM_MASSES
                         - 16384;
    localparam int SQR = (i <= NUM_MASSES / 2) ? 16384 : -16384;
    assign tab[0][i] = sms_pkg::rom_sine(longint'(ANG));
    assign tab[1][i] = 16'(TRI);
    assign tab[2][i] = 16'(SAW);
    assign tab[3][i] = 16'(SQR);
  end

  assign r0 = tab[sel][idx];
  assign r1 = tab[2'(sel + 2'd1)][idx];

endmodule

FILE: sv/sms_head.sv
// ----------------------------------------------------------------------------
// Oscillator head unit
// Three-stage arithmetic pipeline that works on the mass at the ring head.
// ----------------------------------------------------------------------------
module sms_head (
  input  logic               clk,
  input  logic               rst,
  input  logic               iss,
  input  logic [2:0]         kind,
  input  logic               pin,
  input  sms_pkg::mass_t     cur,
  input  logic signed [23:0] nxt_p,
  input  logic signed [23:0] prv_p,
  input  sms_pkg::cfg_t      cfg,
  input  logic signed [15:0] r0,
  input  logic signed [15:0] r1,
  input  logic [7:0]         frac,
  input  logic signed [23:0] exc,
  input  logic [23:0]        fr,
  output sms_pkg::wr_t       wr,
  output sms_pkg::gen_t      gen
);

  // Stage 1 products.
  logic signed [40:0] m1;
  logic signed [48:0] mc;
  logic signed [25:0] d;
  logic signed [50:0] md;
  logic signed [48:0] mz;
  logic [8:0]         w0;
  logic signed [26:0] mix;
  logic signed [24:0] esum;
  logic signed [24:0] gd;
  logic signed [49:0] gp;

  logic               s1_v, s2_v, s3_v;
  logic [2:0]         s1_k, s2_k, s3_k;
  logic               s1_pin, s2_pin, s3_pin;
  sms_pkg::mass_t     s1_m, s2_m, s3_m;
  logic signed [40:0] s1_m1;
  logic signed [48:0] s1_mc, s1_mz;
  logic signed [50:0] s1_md;
  logic signed [26:0] s1_mix, s2_mix, s3_mix;
  logic signed [24:0] s1_sum, s2_sum, s3_sum;
  logic signed [49:0] s1_gp;

  // Stage 2 values.
  logic signed [35:0] fk, fz, fzc;
  logic signed [36:0] diff;
  logic signed [36:0] s2_diff;
  logic signed [23:0] vn;
  logic signed [26:0] y, yq;
  logic signed [27:0] s28;
  logic [11:0]        samp, s2_samp, s3_samp;

  // Stage 3 values.
  logic signed [40:0] m2, s3_m2;
  logic signed [43:0] phi, s3_phi;
  logic [41:0]        plo, s3_plo;
  logic signed [63:0] acc_sum;

  always_comb begin
    w0   = 9'd256 - {1'b0, frac};
    m1   = $signed({1'b0, cfg.step}) * cur.a;
    mc   = cur.p * $signed({1'b0, cfg.cent});
    d    = (26'(prv_p) - 26'(cur.p)) + (26'(nxt_p) - 26'(cur.p));
    md   = d * $signed({1'b0, cfg.stiff});
    mz   = $signed({1'b0, cfg.damp}) * cur.v;
    mix  = 27'(r0) * 27'($signed({1'b0, w0})) + 27'(r1) * 27'($signed({2'b0, frac}));
    esum = 25'(cur.a) + 25'(exc);
    gd   = 25'(nxt_p) - 25'(cur.p);
    gp   = gd * $signed({1'b0, fr});
  end

  always_comb begin
    fk  = 36'(s1_md >>> 16) - 36'(s1_mc >>> 16);
    fz  = 36'(s1_mz >>> 16);
    fzc = fz;
    if ((fk > 0 && fz > fk) || (fk < 0 && fz < fk)) begin
      fzc = fk;
    end
    diff = 37'(fk) - 37'(fzc);
    vn   = sms_pkg::sat24(64'(s1_m.v) + 64'(s1_m1 >>> 16));
    y    = 27'(s1_m.p) + 27'(s1_gp >>> 24);
    yq   = (y < 0) ? -((-y) >>> 7) : (y >>> 7);
    s28  = 28'(yq) + 28'sd2048;
    if (s28 > 28'sd4095) begin
      samp = 12'd4095;
    end else if (s28 < 0) begin
      samp = 12'd0;
    end else begin
      samp = s28[11:0];
    end
  end

  always_comb begin
    m2  = $signed({1'b0, cfg.step}) * s2_m.v;
    phi = $signed(s2_diff[36:18]) * $signed({1'b0, cfg.inv});
    plo = s2_diff[17:0] * cfg.inv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= iss;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_k   <= kind;
    s1_pin <= pin;
    s1_m   <= cur;
    s1_m1  <= m1;
    s1_mc  <= mc;
    s1_md  <= md;
    s1_mz  <= mz;
    s1_mix <= mix;
    s1_sum <= esum;
    s1_gp  <= gp;

    s2_k    <= s1_k;
    s2_pin  <= s1_pin;
    s2_m    <= {s1_m.p, vn, s1_m.a};
    s2_diff <= diff;
    s2_mix  <= s1_mix;
    s2_sum  <= s1_sum;
    s2_samp <= samp;

    s3_k    <= s2_k;
    s3_pin  <= s2_pin;
    s3_m    <= s2_m;
    s3_m2   <= m2;
    s3_phi  <= phi;
    s3_plo  <= plo;
    s3_mix  <= s2_mix;
    s3_sum  <= s2_sum;
    s3_samp <= s2_samp;
  end

  assign acc_sum = (64'(s3_phi) <<< 18) + $signed(64'(s3_plo));

  always_comb begin
    wr      = sms_pkg::NO_WR;
    wr.en   = s3_v && (s3_k != sms_pkg::K_GEN);
    wr.m    = s3_m;
    case (s3_k)
      sms_pkg::K_VP: begin
        wr.wp = 1'b1;
        wr.wv = 1'b1;
        wr.m.p = s3_pin ? 24'sd0 : sms_pkg::sat24(64'(s3_m.p) + 64'(s3_m2 >>> 16));
      end
      sms_pkg::K_ACC: begin
        wr.wa = 1'b1;
        wr.m.a = sms_pkg::sat24(acc_sum >>> 16);
      end
      sms_pkg::K_PLUCK: begin
        wr.wp = 1'b1;
        wr.wv = 1'b1;
        wr.wa = 1'b1;
        wr.m.p = sms_pkg::sat24(64'(s3_mix) >>> 6);
        wr.m.v = '0;
        wr.m.a = '0;
      end
      sms_pkg::K_EXC: begin
        wr.wa = 1'b1;
        wr.m.a = sms_pkg::sat24(64'(s3_sum));
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  assign gen.valid  = s3_v && (s3_k == sms_pkg::K_GEN);
  assign gen.sample = s3_samp;

endmodule

FILE: sv/scanned_mass_spring_oscillator.sv
// ----------------------------------------------------------------------------
// Scanned mass-spring oscillator
// Ring of masses in a rotating chain of cells, updated by a head pipeline.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) takes one beat per command:
// generate, physics step, pluck or excite. in_ready is high only while the
// block is idle. Each generate beat gives min(num_samples, MAX_BURST) output
// beats on out_valid/out_ready, with last set on the final one; the other
// commands give no output beat. Parameters are written through the APB port.
// The user must write them only while the block is idle; it is not enforced.
// The masses sit in a ring of cells that rotates by one every cycle, so the
// head cell sees each mass once per turn of the ring; a three-stage head
// pipeline does all the arithmetic and writes back three cells behind.
// A physics step runs a velocity/position pass, a drain, an acceleration
// pass and a drain; a pluck runs one pass and a drain; an excite waits for
// its mass to reach the head, then drains. Each generated sample waits for
// its mass to rotate to the head, and the next sample starts only once the
// output register is empty. A stalled receiver therefore stalls the scan.
// Reset clears all masses, the scan phase and the registers to their
// defaults; the ring is usable in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "scanned_mass_spring_oscillator_macros.svh"

module scanned_mass_spring_oscillator #(
  parameter int NUM_MASSES = sms_pkg::NUM_MASSES_DEF,
  parameter int MAX_BURST  = sms_pkg::MAX_BURST_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [6:0]         num_samples,
  input  logic [9:0]         shape,
  input  logic [6:0]         mass_index,
  input  logic signed [23:0] excite_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        dac_sample,
  output logic               last
);

  localparam int IW = $clog2(NUM_MASSES);
  // Cell that receives a result: the mass has moved three places past the head.
  localparam int W  = NUM_MASSES - 4;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_MASSES - 1);
  localparam logic [IW:0]   NM = (IW + 1)'(NUM_MASSES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_P1   = 4'd1;
  localparam logic [3:0] S_D1   = 4'd2;
  localparam logic [3:0] S_P2   = 4'd3;
  localparam logic [3:0] S_PK   = 4'd4;
  localparam logic [3:0] S_EX   = 4'd5;
  localparam logic [3:0] S_DN   = 4'd6;
  localparam logic [3:0] S_GQ   = 4'd7;
  localparam logic [3:0] S_GW   = 4'd8;
  localparam logic [3:0] S_GR   = 4'd9;

  sms_pkg::cfg_t  cfg;
  sms_pkg::mass_t ring [NUM_MASSES];
  sms_pkg::wr_t   head_wr;
  sms_pkg::gen_t  gen_res;

  logic [3:0]          state;
  logic [IW-1:0]       head_idx;
  logic [IW-1:0]       cnt;
  logic [1:0]          dcnt;
  logic [6:0]          rem;
  logic [6:0]          burst;
  logic [23:0]         phase;
  logic [IW+24:0]      q;
  logic [1:0]          sel;
  logic [7:0]          frac;
  logic signed [23:0]  exc;
  logic [IW-1:0]       exc_idx;
  logic                in_range;
  logic                iss;
  logic [2:0]          kind;
  logic signed [15:0]  r0, r1;
  logic                cfg_wr;

  // Configuration port: writes complete in the access phase, no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step  <= 16'd655;
      cfg.inv   <= 24'd65536;
      cfg.damp  <= '0;
      cfg.cent  <= '0;
      cfg.stiff <= 24'd65536;
      cfg.pinc  <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        sms_pkg::REG_STEP:  cfg.step  <= pwdata[15:0];
        sms_pkg::REG_INV:   cfg.inv   <= pwdata[23:0];
        sms_pkg::REG_DAMP:  cfg.damp  <= pwdata[23:0];
        sms_pkg::REG_CENT:  cfg.cent  <= pwdata[23:0];
        sms_pkg::REG_STIFF: cfg.stiff <= pwdata[23:0];
        sms_pkg::REG_PINC:  cfg.pinc  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      sms_pkg::REG_STEP:  prdata = {16'd0, cfg.step};
      sms_pkg::REG_INV:   prdata = {8'd0, cfg.inv};
      sms_pkg::REG_DAMP:  prdata = {8'd0, cfg.damp};
      sms_pkg::REG_CENT:  prdata = {8'd0, cfg.cent};
      sms_pkg::REG_STIFF: prdata = {8'd0, cfg.stiff};
      sms_pkg::REG_PINC:  prdata = {8'd0, cfg.pinc};
      default:            prdata = '0;
    endcase
  end

  // The ring: cell k takes cell k+1 each cycle, so the head moves forward by
  // one mass per cycle. Results of the head pipeline merge in at cell W.
  for (genvar k = 0; k < NUM_MASSES; k++) begin : g_cell
    if (k == W) begin : g_wr
      sms_cell u_cell (
        .clk (clk),
        .rst (rst),
        .nbr (ring[(k + 1) % NUM_MASSES]),
        .wr  (head_wr),
        .q   (ring[k])
      );
    end else begin : g_plain
      sms_cell u_cell (
        .clk (clk),
        .rst (rst),
        .nbr (ring[(k + 1) % NUM_MASSES]),
        .wr  (sms_pkg::NO_WR),
        .q   (ring[k])
      );
    end
  end

  // Index of the mass now in the head cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx <= '0;
    end else begin
      head_idx <= (head_idx == LAST_IDX) ? '0 : IW'(head_idx + 1'b1);
    end
  end

  sms_rom #(.NUM_MASSES(NUM_MASSES)) u_rom (
    .idx (head_idx),
    .sel (sel),
    .r0  (r0),
    .r1  (r1)
  );

  sms_head u_head (
    .clk   (clk),
    .rst   (rst),
    .iss   (iss),
    .kind  (kind),
    .pin   (head_idx == '0),
    .cur   (ring[0]),
    .nxt_p (ring[1].p),
    .prv_p (ring[NUM_MASSES - 1].p),
    .cfg   (cfg),
    .r0    (r0),
    .r1    (r1),
    .frac  (frac),
    .exc   (exc),
    .fr    (q[23:0]),
    .wr    (head_wr),
    .gen   (gen_res)
  );

  assign in_ready = (state == S_IDLE);
  assign burst    = (num_samples > 7'(MAX_BURST)) ? 7'(MAX_BURST) : num_samples;
  assign in_range = ({25'd0, mass_index} < 32'(NUM_MASSES));

  // Issue to the head: every cycle in the sweeping states, once for the
  // single-mass commands at their mass, a sample only with out_valid low.
  always_comb begin
    iss  = 1'b0;
    kind = sms_pkg::K_VP;
    case (state)
      S_P1: begin
        iss = 1'b1;
      end
      S_P2: begin
        iss  = 1'b1;
        kind = sms_pkg::K_ACC;
      end
      S_PK: begin
        iss  = 1'b1;
        kind = sms_pkg::K_PLUCK;
      end
      S_EX: begin
        iss  = (head_idx == exc_idx);
        kind = sms_pkg::K_EXC;
      end
      S_GW: begin
        iss  = (head_idx == q[IW+23:24]) && !out_valid;
        kind = sms_pkg::K_GEN;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      dcnt  <= '0;
      rem   <= '0;
      phase <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (operation)
              sms_pkg::OP_GEN: begin
                rem <= burst;
                if (burst != 7'd0) begin
                  state <= S_GQ;
                end
              end
              sms_pkg::OP_STEP: begin
                cnt   <= LAST_IDX;
                state <= S_P1;
              end
              sms_pkg::OP_PLUCK: begin
                cnt   <= LAST_IDX;
                state <= S_PK;
              end
              sms_pkg::OP_EXC: begin
                if (in_range) begin
                  state <= S_EX;
                end
              end
              default: ;
            endcase
          end
        end
        S_P1: begin
          cnt <= IW'(cnt - 1'b1);
          if (cnt == '0) begin
            dcnt  <= 2'd2;
            state <= S_D1;
          end
        end
        S_D1: begin
          dcnt <= 2'(dcnt - 1'b1);
          if (dcnt == 2'd0) begin
            cnt   <= LAST_IDX;
            state <= S_P2;
          end
        end
        S_P2, S_PK: begin
          cnt <= IW'(cnt - 1'b1);
          if (cnt == '0) begin
            dcnt  <= 2'd2;
            state <= S_DN;
          end
        end
        S_EX: begin
          if (iss) begin
            dcnt  <= 2'd2;
            state <= S_DN;
          end
        end
        S_DN: begin
          dcnt <= 2'(dcnt - 1'b1);
          if (dcnt == 2'd0) begin
            state <= S_IDLE;
          end
        end
        S_GQ: begin
          state <= S_GW;
        end
        S_GW: begin
          if (iss) begin
            state <= S_GR;
          end
        end
        S_GR: begin
          if (gen_res.valid) begin
            phase <= phase + cfg.pinc;
            rem   <= 7'(rem - 1'b1);
            state <= (rem == 7'd1) ? S_IDLE : S_GQ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command payload and scan position; no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sel     <= shape[9:8];
      frac    <= shape[7:0];
      exc     <= excite_value;
      exc_idx <= IW'(mass_index);
    end
    if (state == S_GQ) begin
      q <= phase * NM;
    end
  end

  // Output register: one beat, loaded only while it is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (gen_res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_res.valid) begin
      dac_sample <= gen_res.sample;
      last       <= (rem == 7'd1);
    end
  end

  `SMS_ASSERT_IMPL(a_gen_in_gr, clk, rst, gen_res.valid, state == S_GR && !out_valid, "bad sample")
  `SMS_ASSERT_IMPL(a_wr_busy, clk, rst, head_wr.en, state != S_IDLE && state <= S_DN, "stray write")
  `SMS_ASSERT_NEXT(a_last, clk, rst, gen_res.valid && rem == 7'd1, state == S_IDLE && last, "no end")
  `SMS_ASSERT_IMPL(a_head_range, clk, rst, 1'b1, head_idx <= LAST_IDX, "head index beyond the ring")

endmodule

FILE: verif/scanned_mass_spring_oscillator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanned mass-spring oscillator testbench
// Drives command beats and APB register writes into the oscillator, keeps
// its own fixed-point model of the mass ring, and checks every DAC sample
// beat against the predicted sample, field by field, in order.
// ----------------------------------------------------------------------------
module scanned_mass_spring_oscillator_tb;

  localparam int N = 128;
  localparam int BURST = 64;
  // A physics step is the slowest command without output.
  localparam int SETTLE = 2 * N + 40;

  typedef struct {
    logic [1:0]         op;
    logic [6:0]         count;
    logic [9:0]         shp;
    logic [6:0]         midx;
    logic signed [23:0] exc;
  } command_t;

  typedef struct {
    logic [11:0] dac;
    logic        fin;
  } sample_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         operation;
  logic [6:0]         num_samples;
  logic [9:0]         shape;
  logic [6:0]         mass_index;
  logic signed [23:0] excite_value;
  logic               out_valid;
  logic               out_ready;
  logic [11:0]        dac_sample;
  logic               last;

  scanned_mass_spring_oscillator uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .num_samples(num_samples), .shape(shape),
    .mass_index(mass_index), .excite_value(excite_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .dac_sample(dac_sample), .last(last)
  );

  // Stimulus and expectation stores.
  command_t pending_cmds[$];
  sample_t  expected_samples[$];
  int       mismatches;
  int       sender_idle_pct;
  int       receiver_stall_pct;

  // Shadow of the register file.
  logic [15:0] sh_step;
  logic [23:0] sh_inv, sh_damp, sh_cent, sh_stiff, sh_pinc;

  // Shadow of the mass ring, the scan phase and the shape table.
  longint      ring_pos[N];
  longint      ring_vel[N];
  longint      ring_acc[N];
  logic [23:0] scan_ph;
  longint      shape_tab[4][N];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic longint clamp24(input longint x);
    longint r;
    r = x;
    if (x > 8388607) r = 8388607;
    if (x < -8388608) r = -8388608;
    return r;
  endfunction

  // Folded Taylor sine, angle in Q4.28, result in Q1.14.
  function automatic longint sine_q14(input longint ang);
    longint x, x2, t, s;
    bit     flip;
    x = ang;
    flip = 0;
    if (x > 843314857) begin
      x = x - 843314857;
      flip = 1;
    end
    if (x > 421657428) x = 843314857 - x;
    if (x < 0) x = 0;
    x2 = (x * x) >>> 28;
    t = 268435456 - x2 / 72;
    t = 268435456 - ((x2 * t) >>> 28) / 42;
    t = 268435456 - ((x2 * t) >>> 28) / 20;
    t = 268435456 - ((x2 * t) >>> 28) / 6;
    s = (x * t) >>> 28;
    s = (s + 8192) >>> 14;
    if (s > 16384) s = 16384;
    return flip ? -s : s;
  endfunction

  task automatic model_reset();
    longint q;
    q = N / 4;
    sh_step = 16'd655;
    sh_inv = 24'd65536;
    sh_damp = '0;
    sh_cent = '0;
    sh_stiff = 24'd65536;
    sh_pinc = '0;
    scan_ph = '0;
    for (int i = 0; i < N; i++) begin
      ring_pos[i] = 0;
      ring_vel[i] = 0;
      ring_acc[i] = 0;
      shape_tab[0][i] = sine_q14((64'd1674500375 * i) / N);
      if (i < q) begin
        shape_tab[1][i] = (65536 * i) / N;
      end else if (i > N - q) begin
        shape_tab[1][i] = (65536 * ((i + q) % N)) / N - 16384;
      end else begin
        shape_tab[1][i] = 16384 - (65536 * (i - q)) / N;
      end
      shape_tab[2][i] = (32768 * ((i + N / 2) % N)) / N - 16384;
      shape_tab[3][i] = (i <= N / 2) ? 16384 : -16384;
    end
  endtask

  task automatic physics_update();
    longint fk, fz, d;
    for (int i = 0; i < N; i++)
      ring_vel[i] = clamp24(ring_vel[i] + ((longint'(sh_step) * ring_acc[i]) >>> 16));
    for (int i = 0; i < N; i++)
      ring_pos[i] = clamp24(ring_pos[i] + ((longint'(sh_step) * ring_vel[i]) >>> 16));
    ring_pos[0] = 0;
    for (int i = 0; i < N; i++) begin
      d = (ring_pos[(i + N - 1) % N] - ring_pos[i]) + (ring_pos[(i + 1) % N] - ring_pos[i]);
      fk = -((ring_pos[i] * longint'(sh_cent)) >>> 16) + ((d * longint'(sh_stiff)) >>> 16);
      fz = (longint'(sh_damp) * ring_vel[i]) >>> 16;
      // Damping may never push harder than the spring force itself.
      if ((fk > 0 && fz > fk) || (fk < 0 && fz < fk)) fz = fk;
      ring_acc[i] = clamp24(((fk - fz) * longint'(sh_inv)) >>> 16);
    end
  endtask

  // Applies one accepted command to the model and queues its samples.
  task automatic apply_command(input command_t c);
    int          n;
    int          t;
    longint      f, qv, k, fr, a, b, y, s;
    sample_t     smp;
    case (c.op)
      sms_pkg::OP_GEN: begin
        n = (c.count > BURST) ? BURST : c.count;
        for (int j = 0; j < n; j++) begin
          qv = longint'(scan_ph) * N;
          k = (qv >>> 24) % N;
          fr = qv & 64'hFFFFFF;
          a = ring_pos[k];
          b = ring_pos[(k + 1) % N];
          y = a + (((b - a) * fr) >>> 24);
          s = y / 128 + 2048;
          if (s > 4095) s = 4095;
          if (s < 0) s = 0;
          smp.dac = s[11:0];
          smp.fin = (j == n - 1);
          expected_samples.push_back(smp);
          scan_ph = scan_ph + sh_pinc;
        end
      end
      sms_pkg::OP_STEP: physics_update();
      sms_pkg::OP_PLUCK: begin
        t = c.shp[9:8];
        f = c.shp[7:0];
        for (int i = 0; i < N; i++) begin
          ring_pos[i] = clamp24((shape_tab[t][i] * (256 - f) +
                                 shape_tab[(t + 1) % 4][i] * f) >>> 6);
          ring_vel[i] = 0;
          ring_acc[i] = 0;
        end
      end
      default: begin
        if (c.midx < N) ring_acc[c.midx] = clamp24(ring_acc[c.midx] + longint'(c.exc));
      end
    endcase
  endtask

  // Driver: presents the next pending command, idling at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          command_t c;
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          operation <= c.op;
          num_samples <= c.count;
          shape <= c.shp;
          mass_index <= c.midx;
          excite_value <= c.exc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on every accepted command beat, checks every sample beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        command_t c;
        c.op = operation;
        c.count = num_samples;
        c.shp = shape;
        c.midx = mass_index;
        c.exc = excite_value;
        apply_command(c);
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report($sformatf("unexpected sample beat dac=%0d last=%0b", dac_sample, last));
        end else begin
          sample_t e;
          e = expected_samples.pop_front();
          if (dac_sample !== e.dac)
            report($sformatf("dac_sample got %0d want %0d", dac_sample, e.dac));
          if (last !== e.fin)
            report($sformatf("last got %0b want %0b", last, e.fin));
        end
      end
    end
  end

  function automatic command_t make_cmd(input logic [1:0] op, input int cnt,
                                        input int shp, input int midx, input int exc);
    command_t c;
    c.op = op;
    c.count = cnt[6:0];
    c.shp = shp[9:0];
    c.midx = midx[6:0];
    c.exc = exc[23:0];
    return c;
  endfunction

  // A random command of the given kind; all other fields are random noise.
  function automatic command_t random_cmd(input logic [1:0] op);
    command_t c;
    c = make_cmd(op, $urandom, $urandom, $urandom, $urandom);
    // Most bursts are short to keep the run brisk; a few go past the burst cap.
    if (op == sms_pkg::OP_GEN) begin
      c.count = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(16, 1));
    end
    return c;
  endfunction

  // Well-formed sequences (pluck, nudge, settle, listen) plus random noise.
  task automatic queue_random(input int how_many);
    int made;
    int n_exc;
    int n_step;
    int n_gen;
    made = 0;
    while (made < how_many) begin
      if ($urandom_range(99) < 20) begin
        pending_cmds.push_back(random_cmd(2'($urandom_range(3))));
        made++;
      end else begin
        n_exc = $urandom_range(2);
        n_step = $urandom_range(4, 1);
        n_gen = $urandom_range(2, 1);
        pending_cmds.push_back(random_cmd(sms_pkg::OP_PLUCK));
        repeat (n_exc) pending_cmds.push_back(random_cmd(sms_pkg::OP_EXC));
        repeat (n_step) pending_cmds.push_back(random_cmd(sms_pkg::OP_STEP));
        repeat (n_gen) pending_cmds.push_back(random_cmd(sms_pkg::OP_GEN));
        made = made + 1 + n_exc + n_step + n_gen;
      end
    end
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sms_pkg::REG_STEP:  sh_step = value[15:0];
      sms_pkg::REG_INV:   sh_inv = value[23:0];
      sms_pkg::REG_DAMP:  sh_damp = value[23:0];
      sms_pkg::REG_CENT:  sh_cent = value[23:0];
      sms_pkg::REG_STIFF: sh_stiff = value[23:0];
      sms_pkg::REG_PINC:  sh_pinc = value[23:0];
      default: ;
    endcase
  endtask

  // Waits for the queue to drain, every sample to arrive and the block to settle.
  // While this runs the sender has nothing to send, so it also holds off.
  task automatic drain();
    @(negedge clk);
    while (pending_cmds.size() > 0 || in_valid || expected_samples.size() > 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    operation = sms_pkg::OP_GEN;
    num_samples = '0;
    shape = '0;
    mass_index = '0;
    excite_value = '0;
    mismatches = 0;
    sender_idle_pct = 35;
    receiver_stall_pct = 62;
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at reset settings: an idle ring, every morph boundary,
    // burst edges including the zero count and the cap, and saturating excites.
    @(negedge clk);
    pending_cmds.push_back(make_cmd(sms_pkg::OP_GEN, 1, 0, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_PLUCK, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_GEN, 64, 0, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_GEN, 0, 1023, 127, -1));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_PLUCK, 127, 1023, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_PLUCK, 0, 255, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_PLUCK, 0, 256, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_PLUCK, 0, 511, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_PLUCK, 0, 512, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_PLUCK, 0, 767, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_PLUCK, 0, 768, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_EXC, 0, 0, 0, 8388607));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_EXC, 0, 0, 127, -8388608));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_EXC, 0, 0, 127, -8388608));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_EXC, 0, 0, 64, 8388607));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_STEP, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_STEP, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_GEN, 65, 0, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_GEN, 127, 0, 0, 0));
    pending_cmds.push_back(make_cmd(sms_pkg::OP_GEN, 1, 0, 0, 0));
    queue_random(35);
    drain();

    // Middle of the road settings with a live scan; idling swaps sides.
    sender_idle_pct <= 62;
    receiver_stall_pct <= 35;
    apb_write(sms_pkg::REG_STEP, $urandom_range(65535));
    apb_write(sms_pkg::REG_INV, 65536 + $urandom_range(65535));
    apb_write(sms_pkg::REG_DAMP, $urandom_range(131071));
    apb_write(sms_pkg::REG_CENT, $urandom_range(65535));
    apb_write(sms_pkg::REG_STIFF, $urandom_range(262143));
    apb_write(sms_pkg::REG_PINC, $urandom);
    @(negedge clk);
    queue_random(70);
    drain();

    // Every register at its top value; no idling from here on.
    sender_idle_pct <= 0;
    receiver_stall_pct <= 0;
    apb_write(sms_pkg::REG_STEP, 32'hFFFF);
    apb_write(sms_pkg::REG_INV, 32'hFFFFFF);
    apb_write(sms_pkg::REG_DAMP, 32'hFFFFFF);
    apb_write(sms_pkg::REG_CENT, 32'hFFFFFF);
    apb_write(sms_pkg::REG_STIFF, 32'hFFFFFF);
    apb_write(sms_pkg::REG_PINC, 32'hFFFFFF);
    @(negedge clk);
    queue_random(65);
    drain();

    // Every register at zero except a fast scan.
    apb_write(sms_pkg::REG_STEP, 0);
    apb_write(sms_pkg::REG_INV, 0);
    apb_write(sms_pkg::REG_DAMP, 0);
    apb_write(sms_pkg::REG_CENT, 0);
    apb_write(sms_pkg::REG_STIFF, 0);
    apb_write(sms_pkg::REG_PINC, 32'h3FFFFF & $urandom);
    @(negedge clk);
    queue_random(65);
    drain();

    if (mismatches == 0) begin
      $display("scanned_mass_spring_oscillator_tb: PASS");
    end else begin
      $display("scanned_mass_spring_oscillator_tb: FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("scanned_mass_spring_oscillator_tb: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/sms_pkg.sv
sv/sms_cell.sv
sv/sms_rom.sv
sv/sms_head.sv
sv/scanned_mass_spring_oscillator.sv
verif/scanned_mass_spring_oscillator_tb.sv
